FILE: sv/dstq_pkg.sv
// Shared types and codes for the deadline-sorted task queue.
// No dependencies; used by the queue top level.
`timescale 1ns / 1ps

package dstq_pkg;

    // Default queue depth
    localparam int DEPTH_DEF = 16;

    // Operation codes on i_mode
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // Status codes on o_status
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Saturation limits of the result fields
    localparam int          COUNT_MAX = 31;
    localparam logic [11:0] SUM_MAX   = 12'hFFF;

    // One stored task
    typedef struct packed {
        logic [15:0] deadline;
        logic [7:0]  hours;
        logic [7:0]  owner;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

FILE: sv/deadline_sorted_task_queue_unit.sv
// Deadline-sorted task queue: top level with its sequencer.
// Depends on dstq_pkg and dstq_ram.
//
// Usage:
//   Command channel: drive i_mode and the task fields and raise start; the
//   command transfers at a rising edge where start is high and busy is low.
//   busy stays high until the command has finished.
//   Result channel: o_done is high for exactly one cycle per command, with
//   o_status, o_entry_count, the head task and o_workload_sum valid in that
//   cycle. The receiver cannot stall; the fields hold until the next command updates them.
//   A new command may transfer in the cycle o_done is high.
// Work per command: the single RAM port pair moves or scans one entry per
//   cycle. Insert moves each stored task with deadline >= new deadline up one
//   slot; remove moves every stored task but the head down one slot; query
//   scans every stored task. A dropped insert, an empty remove and mode 3 touch no entry.
// Reset: synchronous, active low; empties the queue. Task storage is not
//   cleared; only entries below the count are ever used.
`timescale 1ns / 1ps

module deadline_sorted_task_queue_unit #(
    parameter int DEPTH = dstq_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_task_deadline,
    input  logic [7:0]  i_task_hours,
    input  logic [7:0]  i_developer_id,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [4:0]  o_entry_count,
    output logic [15:0] o_head_deadline,
    output logic [7:0]  o_head_hours,
    output logic [7:0]  o_head_developer,
    output logic [11:0] o_workload_sum
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_REM  = 3'd2;
    localparam logic [2:0] S_QRY  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_idx, n_idx;
    logic [15:0]          r_dl, n_dl;
    logic [7:0]           r_hr, n_hr;
    logic [7:0]           r_dev, n_dev;
    logic                 r_strobe, n_strobe;
    logic [1:0]           r_status, n_status;
    logic [11:0]          r_sum, n_sum;
    dstq_pkg::t_entry     r_head, n_head;

    // RAM interface
    logic                 ram_we;
    logic [CW-1:0]        wr_idx, rd_idx;
    dstq_pkg::t_entry     wr_entry, rd_entry;
    logic [dstq_pkg::ENTRY_W-1:0] ram_rdata;
    logic [12:0]          sum_ext;

    dstq_ram #(
        .WIDTH (dstq_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_idx[AW-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = dstq_pkg::t_entry'(ram_rdata);
    assign sum_ext  = {1'b0, r_sum} + {5'd0, rd_entry.hours};

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_dl     = r_dl;
        n_hr     = r_hr;
        n_dev    = r_dev;
        n_strobe = 1'b0;
        n_status = r_status;
        n_sum    = r_sum;
        n_head   = r_head;
        ram_we   = 1'b0;
        wr_idx   = r_idx;
        wr_entry = rd_entry;
        rd_idx   = r_count - CW'(1);

        unique case (r_state)
            S_IDLE: begin
                // prefetch the first entry the command will need
                if (i_mode == dstq_pkg::MODE_REMOVE) begin
                    rd_idx = CW'(1);
                end else if (i_mode == dstq_pkg::MODE_QUERY) begin
                    rd_idx = '0;
                end
                if (start) begin
                    n_dl     = i_task_deadline;
                    n_hr     = i_task_hours;
                    n_dev    = i_developer_id;
                    n_status = dstq_pkg::STAT_OK;
                    n_sum    = '0;
                    n_idx    = '0;
                    case (i_mode)
                        dstq_pkg::MODE_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = dstq_pkg::STAT_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_INS;
                            end
                        end
                        dstq_pkg::MODE_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = dstq_pkg::STAT_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_REM;
                            end
                        end
                        dstq_pkg::MODE_QUERY: n_state = S_QRY;
                        default:              n_state = S_DONE;
                    endcase
                end
            end

            S_INS: begin
                // walk from the tail, moving later-or-equal deadlines up one slot
                ram_we = 1'b1;
                wr_idx = r_idx;
                if (r_idx != '0 && rd_entry.deadline >= r_dl) begin
                    wr_entry = rd_entry;
                    n_idx    = r_idx - CW'(1);
                    rd_idx   = r_idx - CW'(2);
                end else begin
                    wr_entry.deadline = r_dl;
                    wr_entry.hours    = r_hr;
                    wr_entry.owner    = r_dev;
                    n_count  = r_count + CW'(1);
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_REM: begin
                // move entry idx+1 down to idx
                if (r_idx + CW'(1) >= r_count) begin
                    n_count  = r_count - CW'(1);
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    ram_we   = 1'b1;
                    wr_idx   = r_idx;
                    wr_entry = rd_entry;
                    n_idx    = r_idx + CW'(1);
                    rd_idx   = r_idx + CW'(2);
                end
            end

            S_QRY: begin
                // one entry per cycle, saturating accumulate
                if (r_idx >= r_count) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    if (rd_entry.owner == r_dev) begin
                        n_sum = sum_ext[12] ? dstq_pkg::SUM_MAX : sum_ext[11:0];
                    end
                    n_idx  = r_idx + CW'(1);
                    rd_idx = r_idx + CW'(1);
                end
            end

            S_DONE: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase

        // shadow copy of entry 0
        if (ram_we && wr_idx == '0) begin
            n_head = wr_entry;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_idx    <= n_idx;
        r_dl     <= n_dl;
        r_hr     <= n_hr;
        r_dev    <= n_dev;
        r_status <= n_status;
        r_sum    <= n_sum;
        r_head   <= n_head;
    end

    // Outputs; count and head do not change while o_done is high
    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_strobe;
    assign o_status = r_status;
    assign o_workload_sum = r_sum;
    assign o_entry_count  = (32'(r_count) > dstq_pkg::COUNT_MAX)
                          ? 5'(dstq_pkg::COUNT_MAX) : 5'(r_count);
    assign o_head_deadline  = (r_count == '0) ? 16'd0 : r_head.deadline;
    assign o_head_hours     = (r_count == '0) ? 8'd0  : r_head.hours;
    assign o_head_developer = (r_count == '0) ? 8'd0  : r_head.owner;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= DEPTH)
        else $error("queue count beyond depth");

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state) != S_IDLE)
        else $error("result strobe without a command in progress");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status == dstq_pkg::STAT_FULL) |-> r_count == CW'(DEPTH))
        else $error("full status with room left");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status == dstq_pkg::STAT_EMPTY) |-> r_count == '0)
        else $error("empty status on a non-empty queue");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_INS || r_state == S_REM))
        else $error("store written outside insert or remove");

endmodule

FILE: sv/dstq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module dstq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
